FILE: rtl/core/isrch_pkg.sv
package isrch_pkg;

  // Storage geometry
  localparam int MAX_ELEMENTS = 1024;
  localparam int INDEX_STRIDE = 10;
  localparam int IDX_DEPTH    = MAX_ELEMENTS / INDEX_STRIDE + 2;

  // Field widths
  localparam int VAL_W = 30;
  localparam int POS_W = 10;

  // Derived widths
  localparam int CNT_W   = $clog2(MAX_ELEMENTS + 1);
  localparam int ADDR_W  = $clog2(MAX_ELEMENTS);
  localparam int IDX_AW  = $clog2(IDX_DEPTH);
  localparam int SZ_W    = $clog2(IDX_DEPTH + 1);
  localparam int REM_W   = $clog2(INDEX_STRIDE);
  localparam int START_W = $clog2(IDX_DEPTH * INDEX_STRIDE + 1);

  // Transaction kinds
  localparam logic KIND_APPEND = 1'b0;
  localparam logic KIND_SEARCH = 1'b1;

  typedef logic [VAL_W-1:0] val_t;

  // Append request toward the store
  typedef struct packed {
    logic en;
    val_t value;
    logic fresh;
  } isrch_app_t;

  // Read request toward the store (one address serves both memories)
  typedef struct packed {
    logic             idx_re;
    logic             elem_re;
    logic [CNT_W-1:0] addr;
  } isrch_rd_t;

  // List status from the store
  typedef struct packed {
    logic [CNT_W-1:0]  count;
    logic [IDX_AW-1:0] blk;
    logic              rem_nz;
    logic              ovf;
    val_t              first_val;
  } isrch_stat_t;

endpackage

FILE: rtl/core/isrch_if.sv
interface isrch_in_if;
  logic               valid;
  logic               ready;
  logic               kind;
  isrch_pkg::val_t    key_value;
  logic               first_of_list;

  modport source (output valid, output kind, output key_value, output first_of_list,
                  input ready);
  modport sink   (input valid, input kind, input key_value, input first_of_list,
                  output ready);
endinterface

interface isrch_out_if;
  logic                        valid;
  logic                        ready;
  logic                        found;
  logic [isrch_pkg::POS_W-1:0] position;
  logic                        list_overflowed;

  modport source (output valid, output found, output position, output list_overflowed,
                  input ready);
  modport sink   (input valid, input found, input position, input list_overflowed,
                  output ready);
endinterface

FILE: rtl/core/isrch_store.sv
module isrch_store (
  input  logic                   clk,
  input  logic                   rst_n,
  input  isrch_pkg::isrch_app_t  app,
  input  isrch_pkg::isrch_rd_t   rd,
  output isrch_pkg::val_t        elem_rd_data,
  output isrch_pkg::val_t        idx_rd_data,
  output isrch_pkg::isrch_stat_t stat
);

  logic [isrch_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic [isrch_pkg::IDX_AW-1:0] blk_r, blk_nxt;
  logic [isrch_pkg::REM_W-1:0]  rem_r, rem_nxt;
  logic                         ovf_r, ovf_nxt;
  isrch_pkg::val_t              first_r;

  logic [isrch_pkg::CNT_W-1:0]  base_cnt;
  logic [isrch_pkg::IDX_AW-1:0] base_blk;
  logic [isrch_pkg::REM_W-1:0]  base_rem;
  logic                         base_ovf;
  logic [isrch_pkg::IDX_AW:0]   idx_wa_wide;
  logic                         elem_we, idx_we, first_we;

  isrch_pkg::val_t elem_mem [isrch_pkg::MAX_ELEMENTS];
  isrch_pkg::val_t idx_mem  [isrch_pkg::IDX_DEPTH];
  isrch_pkg::val_t elem_q_r, idx_q_r;

  always_comb begin
    base_cnt    = app.fresh ? '0 : count_r;
    base_blk    = app.fresh ? '0 : blk_r;
    base_rem    = app.fresh ? '0 : rem_r;
    base_ovf    = app.fresh ? 1'b0 : ovf_r;
    // new element p lands in index entry p/STRIDE+1 in every case
    idx_wa_wide = {1'b0, base_blk} + (isrch_pkg::IDX_AW + 1)'(1);
    count_nxt   = count_r;
    blk_nxt     = blk_r;
    rem_nxt     = rem_r;
    ovf_nxt     = ovf_r;
    elem_we     = 1'b0;
    idx_we      = 1'b0;
    first_we    = 1'b0;
    if (app.en) begin
      count_nxt = base_cnt;
      blk_nxt   = base_blk;
      rem_nxt   = base_rem;
      ovf_nxt   = base_ovf;
      if (base_cnt >= isrch_pkg::CNT_W'(isrch_pkg::MAX_ELEMENTS)) begin
        ovf_nxt = 1'b1;
      end else begin
        elem_we   = 1'b1;
        first_we  = (base_cnt == '0);
        idx_we    = (idx_wa_wide < (isrch_pkg::IDX_AW + 1)'(isrch_pkg::IDX_DEPTH));
        count_nxt = base_cnt + isrch_pkg::CNT_W'(1);
        if (base_rem == isrch_pkg::REM_W'(isrch_pkg::INDEX_STRIDE - 1)) begin
          blk_nxt = base_blk + isrch_pkg::IDX_AW'(1);
          rem_nxt = '0;
        end else begin
          rem_nxt = base_rem + isrch_pkg::REM_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      blk_r   <= '0;
      rem_r   <= '0;
      ovf_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      blk_r   <= blk_nxt;
      rem_r   <= rem_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (first_we) begin
      first_r <= app.value;
    end
  end

  always_ff @(posedge clk) begin
    if (elem_we) begin
      elem_mem[base_cnt[isrch_pkg::ADDR_W-1:0]] <= app.value;
    end
    if (rd.elem_re) begin
      elem_q_r <= elem_mem[rd.addr[isrch_pkg::ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (idx_we) begin
      idx_mem[idx_wa_wide[isrch_pkg::IDX_AW-1:0]] <= app.value;
    end
    if (rd.idx_re) begin
      idx_q_r <= idx_mem[rd.addr[isrch_pkg::IDX_AW-1:0]];
    end
  end

  assign elem_rd_data     = elem_q_r;
  assign idx_rd_data      = idx_q_r;
  assign stat.count       = count_r;
  assign stat.blk         = blk_r;
  assign stat.rem_nz      = (rem_r != '0);
  assign stat.ovf         = ovf_r;
  assign stat.first_val   = first_r;

endmodule

FILE: rtl/core/indexed_sequential_search.sv
// Indexed sequential search over a sorted list. Each input transaction is
// either an append (kind 0), which stores key_value as the next element of
// the list (first_of_list starts a new list and clears the overflow flag), or
// a search (kind 1), which returns one result transaction with found, the
// 0-based position of the match, and list_overflowed. Appends beyond 1024
// elements are dropped and flagged. An append produces no result. A
// search walks the sparse index (the first element, every tenth element,
// and the last element), one index memory read per cycle, then walks the
// element memory from the derived start point, one read per cycle, until
// it hits a match or a larger element. Entry 0 sits in a register, so a
// full list checks at most 103 index entries, and a sorted list stops
// within 11 elements. A key not above the first element skips the index.
// A list stored out of order can walk every stored element. One search is
// in flight at a time; in_ch.ready stays low while it runs. A finished
// result sits in an output register, so appends are taken while it waits
// for out_ch.ready; a search that finishes before the previous result is
// taken holds until the output register frees up.
module indexed_sequential_search (
  input  logic         clk,
  input  logic         rst_n,
  isrch_in_if.sink     in_ch,
  isrch_out_if.source  out_ch
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ISCAN = 2'd1;
  localparam logic [1:0] ST_ESCAN = 2'd2;
  localparam logic [1:0] ST_RES   = 2'd3;

  logic [1:0] state_r, state_nxt;

  // search context
  isrch_pkg::val_t              key_r, key_nxt;
  logic [isrch_pkg::SZ_W-1:0]   size_r, size_nxt;
  logic [isrch_pkg::CNT_W-1:0]  tail_r, tail_nxt;

  // streaming read pointer and the entry whose data is at the memory output
  logic [isrch_pkg::CNT_W-1:0]  rd_addr_r, rd_addr_nxt;
  logic                         chk_vld_r, chk_vld_nxt;
  logic [isrch_pkg::CNT_W-1:0]  chk_addr_r, chk_addr_nxt;

  // finished result waiting for the output register
  logic                         res_found_r, res_found_nxt;
  logic [isrch_pkg::POS_W-1:0]  res_pos_r, res_pos_nxt;
  logic                         res_ovf_r, res_ovf_nxt;

  // output register
  logic                         out_valid_r, out_valid_nxt;
  logic                         out_found_r, out_found_nxt;
  logic [isrch_pkg::POS_W-1:0]  out_pos_r, out_pos_nxt;
  logic                         out_ovf_r, out_ovf_nxt;

  isrch_pkg::isrch_app_t  app;
  isrch_pkg::isrch_rd_t   rd;
  isrch_pkg::isrch_stat_t stat;
  isrch_pkg::val_t        elem_rd_data, idx_rd_data;

  logic                         in_acc;
  logic [isrch_pkg::SZ_W-1:0]   size_full, size_c;
  logic [isrch_pkg::START_W-1:0] tail_prod, mid_prod;
  logic [isrch_pkg::CNT_W-1:0]  tail_c, start_c;
  logic                         idx_gt, idx_last, issue_i;
  logic [isrch_pkg::SZ_W-1:0]   j_stop;
  logic                         elem_eq, elem_gt, elem_last, issue_e;

  isrch_store u_store (
    .clk          (clk),
    .rst_n        (rst_n),
    .app          (app),
    .rd           (rd),
    .elem_rd_data (elem_rd_data),
    .idx_rd_data  (idx_rd_data),
    .stat         (stat)
  );

  // Take a new transaction only between searches
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign app.en    = in_acc && (in_ch.kind == isrch_pkg::KIND_APPEND);
  assign app.value = in_ch.key_value;
  assign app.fresh = in_ch.first_of_list;

  // Index length: first entry, one per full stride, one for a partial tail
  always_comb begin
    size_full = isrch_pkg::SZ_W'(1) + isrch_pkg::SZ_W'(stat.blk)
              + isrch_pkg::SZ_W'(stat.rem_nz);
    size_c    = (size_full > isrch_pkg::SZ_W'(isrch_pkg::IDX_DEPTH))
              ? isrch_pkg::SZ_W'(isrch_pkg::IDX_DEPTH) : size_full;
    // start used when the index walk runs to its last entries
    tail_prod = isrch_pkg::START_W'(size_c - isrch_pkg::SZ_W'(2))
              * isrch_pkg::START_W'(isrch_pkg::INDEX_STRIDE);
    tail_c    = (tail_prod != '0) ? isrch_pkg::CNT_W'(tail_prod - isrch_pkg::START_W'(1))
              : '0;
  end

  // Index walk: stop at the first entry not below the key, or past the end
  always_comb begin
    idx_gt   = (key_r > idx_rd_data);
    idx_last = (chk_addr_r + isrch_pkg::CNT_W'(1) == isrch_pkg::CNT_W'(size_r));
    issue_i  = (rd_addr_r < isrch_pkg::CNT_W'(size_r));
    j_stop   = idx_gt ? isrch_pkg::SZ_W'(chk_addr_r + isrch_pkg::CNT_W'(1))
                      : isrch_pkg::SZ_W'(chk_addr_r);
    mid_prod = isrch_pkg::START_W'(j_stop - isrch_pkg::SZ_W'(1))
             * isrch_pkg::START_W'(isrch_pkg::INDEX_STRIDE)
             - isrch_pkg::START_W'(1);
    if (j_stop > isrch_pkg::SZ_W'(1)) begin
      start_c = (j_stop < size_r - isrch_pkg::SZ_W'(1)) ? isrch_pkg::CNT_W'(mid_prod)
                                                        : tail_r;
    end else begin
      start_c = '0;
    end
  end

  // Element walk: stop at a match, a larger element, or the list end
  always_comb begin
    elem_eq   = (elem_rd_data == key_r);
    elem_gt   = (elem_rd_data > key_r);
    elem_last = (chk_addr_r + isrch_pkg::CNT_W'(1) == stat.count);
    issue_e   = (rd_addr_r < stat.count);
  end

  always_comb begin
    state_nxt     = state_r;
    key_nxt       = key_r;
    size_nxt      = size_r;
    tail_nxt      = tail_r;
    rd_addr_nxt   = rd_addr_r;
    chk_vld_nxt   = 1'b0;
    chk_addr_nxt  = rd_addr_r;
    res_found_nxt = res_found_r;
    res_pos_nxt   = res_pos_r;
    res_ovf_nxt   = res_ovf_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_found_nxt = out_found_r;
    out_pos_nxt   = out_pos_r;
    out_ovf_nxt   = out_ovf_r;
    rd            = '0;
    rd.addr       = rd_addr_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_ch.kind == isrch_pkg::KIND_SEARCH)) begin
          key_nxt       = in_ch.key_value;
          size_nxt      = size_c;
          tail_nxt      = tail_c;
          res_found_nxt = 1'b0;
          res_pos_nxt   = '0;
          res_ovf_nxt   = stat.ovf;
          if (stat.count == '0) begin
            // empty list: report not found right away
            state_nxt = ST_RES;
          end else if (in_ch.key_value > stat.first_val) begin
            // entry 0 lives in a register; stream the index from entry 1
            rd_addr_nxt = isrch_pkg::CNT_W'(1);
            state_nxt   = ST_ISCAN;
          end else begin
            rd_addr_nxt = '0;
            state_nxt   = ST_ESCAN;
          end
        end
      end
      ST_ISCAN: begin
        if (chk_vld_r && (!idx_gt || idx_last)) begin
          // drop any read in flight and restart at the element start point
          rd_addr_nxt = start_c;
          state_nxt   = ST_ESCAN;
        end else begin
          rd.idx_re   = issue_i;
          chk_vld_nxt = issue_i;
          if (issue_i) begin
            rd_addr_nxt = rd_addr_r + isrch_pkg::CNT_W'(1);
          end
        end
      end
      ST_ESCAN: begin
        if (chk_vld_r && (elem_eq || elem_gt || elem_last)) begin
          res_found_nxt = elem_eq;
          res_pos_nxt   = elem_eq ? isrch_pkg::POS_W'(chk_addr_r) : '0;
          state_nxt     = ST_RES;
        end else begin
          rd.elem_re  = issue_e;
          chk_vld_nxt = issue_e;
          if (issue_e) begin
            rd_addr_nxt = rd_addr_r + isrch_pkg::CNT_W'(1);
          end
        end
      end
      ST_RES: begin
        // hold until the output register is free
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = res_found_r;
          out_pos_nxt   = res_pos_r;
          out_ovf_nxt   = res_ovf_r;
          state_nxt     = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      chk_vld_r   <= chk_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r       <= key_nxt;
    size_r      <= size_nxt;
    tail_r      <= tail_nxt;
    rd_addr_r   <= rd_addr_nxt;
    chk_addr_r  <= chk_addr_nxt;
    res_found_r <= res_found_nxt;
    res_pos_r   <= res_pos_nxt;
    res_ovf_r   <= res_ovf_nxt;
    out_found_r <= out_found_nxt;
    out_pos_r   <= out_pos_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.found           = out_found_r;
  assign out_ch.position        = out_pos_r;
  assign out_ch.list_overflowed = out_ovf_r;

endmodule

FILE: rtl/core/isrch_chk.sv
module isrch_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        in_kind,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_found,
  input logic [isrch_pkg::POS_W-1:0] out_position
);

  // A result stays offered until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before it was taken");

  // Reset empties the output register
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  // A miss reports position zero
  a_miss_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_position == '0)
    else $error("miss with nonzero position");

  // An append never creates a result
  a_append_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_kind == isrch_pkg::KIND_APPEND) && !out_valid
      |=> !out_valid)
    else $error("append produced a result");

  // A search occupies the block for at least the next cycle
  a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_kind == isrch_pkg::KIND_SEARCH) |=> !in_ready)
    else $error("new transaction taken during a search");

endmodule

bind indexed_sequential_search isrch_chk u_isrch_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .in_kind      (in_ch.kind),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_found    (out_ch.found),
  .out_position (out_ch.position)
);

FILE: tb/tb_indexed_sequential_search.sv
module tb_indexed_sequential_search;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned KEY_MAX     = 1000000000;
  localparam int          ITEM_TARGET = 1850;
  // Longest quiet stretch of a correct run: sender gap, a full-list search,
  // a held result and a receiver stall; taken ~10x over.
  localparam int          STALL_LIMIT = 2000;
  // Tail after the last result.
  localparam int          TAIL_CYCLES = 200;

  typedef struct packed {
    logic                        found;
    logic [isrch_pkg::POS_W-1:0] position;
    logic                        list_overflowed;
  } search_result_t;

  // Shadow copy of the list and its sparse index; predicts each search
  // transaction and keeps the expected results in arrival order.
  class search_scoreboard;
    isrch_pkg::val_t elems [isrch_pkg::MAX_ELEMENTS];
    isrch_pkg::val_t index_col [isrch_pkg::IDX_DEPTH];
    int              count;
    logic            ovf;
    search_result_t  pending[$];
    int              mismatches, appends, dropped, searches, hits, ovf_results;

    function new();
      count = 0;
      ovf = 1'b0;
    endfunction

    function void note_item(logic op, isrch_pkg::val_t v, logic fresh);
      int n, size, j, start, t, k;
      search_result_t exp;
      if (op == isrch_pkg::KIND_APPEND) begin
        appends++;
        if (fresh) begin
          count = 0;
          ovf = 1'b0;
        end
        if (count >= isrch_pkg::MAX_ELEMENTS) begin
          ovf = 1'b1;
          dropped++;
        end else begin
          elems[count] = v;
          if (count == 0) index_col[0] = v;
          // Every stride boundary gets a fixed entry; otherwise the entry
          // past the last boundary tracks the tail of the list.
          if ((count + 1) % isrch_pkg::INDEX_STRIDE == 0) begin
            index_col[(count + 1) / isrch_pkg::INDEX_STRIDE] = v;
          end else begin
            t = (count + 1) / isrch_pkg::INDEX_STRIDE + 1;
            if (t < isrch_pkg::IDX_DEPTH) index_col[t] = v;
          end
          count++;
        end
      end else begin
        searches++;
        exp = '0;
        exp.list_overflowed = ovf;
        n = count;
        if (n != 0) begin
          size = 1 + n / isrch_pkg::INDEX_STRIDE
               + ((n % isrch_pkg::INDEX_STRIDE != 0) ? 1 : 0);
          if (size > isrch_pkg::IDX_DEPTH) size = isrch_pkg::IDX_DEPTH;
          j = 0;
          while (j < size && v > index_col[j]) j++;
          start = 0;
          if (j > 1) begin
            if (j < size - 1) begin
              start = (j - 1) * isrch_pkg::INDEX_STRIDE - 1;
            end else begin
              // Short lists would land on -1 here; clamp to the head.
              t = (size - 2) * isrch_pkg::INDEX_STRIDE;
              start = (t > 0) ? t - 1 : 0;
            end
          end
          for (k = start; k < n; k++) begin
            if (elems[k] == v) begin
              exp.found = 1'b1;
              exp.position = k[isrch_pkg::POS_W-1:0];
              break;
            end
            if (elems[k] > v) break;
          end
        end
        if (exp.found) hits++;
        if (exp.list_overflowed) ovf_results++;
        pending.insert(pending.size(), exp);
      end
    endfunction

    function void check_result(search_result_t got);
      search_result_t exp;
      if (pending.size() == 0) begin
        mismatches++;
        $display("%0t: result with no search outstanding: found=%0d position=%0d ovf=%0d",
                 $time, got.found, got.position, got.list_overflowed);
      end else begin
        exp = pending.pop_front();
        if (got.found !== exp.found) begin
          mismatches++;
          $display("%0t: found mismatch: expected %0d, got %0d", $time, exp.found,
                   got.found);
        end
        if (got.position !== exp.position) begin
          mismatches++;
          $display("%0t: position mismatch: expected %0d, got %0d", $time, exp.position,
                   got.position);
        end
        if (got.list_overflowed !== exp.list_overflowed) begin
          mismatches++;
          $display("%0t: list_overflowed mismatch: expected %0d, got %0d", $time,
                   exp.list_overflowed, got.list_overflowed);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  isrch_in_if  in_ch();
  isrch_out_if out_ch();

  indexed_sequential_search uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  search_scoreboard sb = new();

  int          items_sent = 0;
  int          quiet_cycles = 0;
  bit          src_gaps = 1'b1;     // sender idles between transactions
  bit          sink_gaps = 1'b1;    // receiver stalls before each result
  int unsigned tail_val;            // last value appended to the current list
  int unsigned step_max;            // largest gap between neighbors of a list
  int unsigned list_vals[$];        // every value offered to the current list

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Sample both channels at the rising edge. Check results before noting new
  // inputs so the expectation queue stays in order when both move together.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        sb.check_result({out_ch.found, out_ch.position, out_ch.list_overflowed});
      end
      if (in_ch.valid && in_ch.ready) begin
        sb.note_item(in_ch.kind, in_ch.key_value, in_ch.first_of_list);
      end
      // Count cycles where neither channel moves a transaction.
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("indexed_sequential_search test failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Result side: draw a stall before each result, hold ready until it lands.
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      stall = sink_gaps ? $urandom_range(0, 19) : 0;
      if (stall > 0) begin
        out_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Drive one input transaction. Call at a falling edge; return at the
  // falling edge after acceptance with valid still high, so a back-to-back
  // transaction just overwrites the payload.
  task automatic send_item(input logic op, input int unsigned value, input logic fresh);
    int gap;
    gap = src_gaps ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.kind          = op;
    in_ch.key_value     = value[isrch_pkg::VAL_W-1:0];
    in_ch.first_of_list = fresh;
    in_ch.valid         = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  // Hold off the sender until every outstanding search has reported.
  task automatic drain_results();
    in_ch.valid = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  // Issue searches whose keys hit, straddle or miss the current list.
  task automatic search_some(input int cnt);
    int          i;
    int unsigned key, lo, hi;
    for (i = 0; i < cnt; i++) begin
      if (list_vals.size() == 0) begin
        key = $urandom_range(1, KEY_MAX);
      end else begin
        lo = list_vals[0];
        hi = list_vals[list_vals.size() - 1];
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: key = list_vals[$urandom_range(0, list_vals.size() - 1)];
          5: begin
            key = list_vals[$urandom_range(0, list_vals.size() - 1)];
            if ($urandom_range(0, 1) && key < KEY_MAX) key = key + 1;
            else if (key > 1) key = key - 1;
          end
          6: key = $urandom_range(1, KEY_MAX);
          7: key = $urandom_range(1, lo);
          8: key = $urandom_range(hi, KEY_MAX);
          default: key = $urandom_range(0, 1) ? lo : hi;
        endcase
      end
      send_item(isrch_pkg::KIND_SEARCH, key, 1'($urandom_range(0, 1)));
    end
  endtask

  // Append len values; ordered lists climb from tail_val by up to step_max,
  // others are scattered. Drop an occasional search in between.
  task automatic grow_list(input int len, input bit fresh, input bit ordered);
    int          i;
    int unsigned v;
    for (i = 0; i < len; i++) begin
      if (!ordered) begin
        v = $urandom_range(1, KEY_MAX);
      end else if (fresh && i == 0) begin
        v = tail_val;
      end else begin
        v = tail_val + $urandom_range(0, step_max);
        if (v > KEY_MAX) v = KEY_MAX;
      end
      tail_val = v;
      if (fresh && i == 0) list_vals.delete();
      list_vals.insert(list_vals.size(), v);
      send_item(isrch_pkg::KIND_APPEND, v, fresh && i == 0);
      if ($urandom_range(0, 9) == 0) search_some(1);
    end
  endtask

  initial begin
    int len;
    int pick;
    bit ordered;
    bit overflow_done;

    overflow_done = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.kind = isrch_pkg::KIND_APPEND;
    in_ch.key_value = '0;
    in_ch.first_of_list = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty list, single element, short list past its end (the
    // start position clamps to the head), duplicates, key extremes, and a
    // list stored out of order.
    send_item(isrch_pkg::KIND_SEARCH, 1, 1'b0);
    send_item(isrch_pkg::KIND_SEARCH, KEY_MAX, 1'b1);
    send_item(isrch_pkg::KIND_APPEND, 1, 1'b1);
    send_item(isrch_pkg::KIND_SEARCH, 1, 1'b0);
    send_item(isrch_pkg::KIND_SEARCH, KEY_MAX, 1'b0);
    send_item(isrch_pkg::KIND_APPEND, 5, 1'b1);
    send_item(isrch_pkg::KIND_APPEND, 10, 1'b0);
    send_item(isrch_pkg::KIND_APPEND, 15, 1'b0);
    send_item(isrch_pkg::KIND_SEARCH, 10, 1'b0);
    send_item(isrch_pkg::KIND_SEARCH, 12, 1'b0);
    send_item(isrch_pkg::KIND_SEARCH, 20, 1'b1);
    send_item(isrch_pkg::KIND_SEARCH, 3, 1'b0);
    send_item(isrch_pkg::KIND_APPEND, 7, 1'b1);
    send_item(isrch_pkg::KIND_APPEND, 7, 1'b0);
    send_item(isrch_pkg::KIND_APPEND, KEY_MAX, 1'b0);
    send_item(isrch_pkg::KIND_SEARCH, 7, 1'b0);
    send_item(isrch_pkg::KIND_SEARCH, KEY_MAX, 1'b0);
    send_item(isrch_pkg::KIND_APPEND, 50, 1'b1);
    send_item(isrch_pkg::KIND_APPEND, 20, 1'b0);
    send_item(isrch_pkg::KIND_SEARCH, 20, 1'b0);
    send_item(isrch_pkg::KIND_SEARCH, 50, 1'b0);
    drain_results();

    // Random lists: mostly short sorted ones, some longer, a few unsorted,
    // and one run past the full store so later appends get dropped.
    while (items_sent < ITEM_TARGET) begin
      src_gaps  = ($urandom_range(0, 3) != 0);
      sink_gaps = ($urandom_range(0, 3) != 0);
      ordered = 1'b1;
      if (!overflow_done && items_sent >= 400) begin
        len = isrch_pkg::MAX_ELEMENTS + $urandom_range(1, 6);
        overflow_done = 1'b1;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          ordered = 1'b0;
          len = $urandom_range(1, 30);
        end else if (pick < 75) begin
          len = $urandom_range(1, 40);
        end else if (pick < 96) begin
          len = $urandom_range(41, 200);
        end else begin
          len = $urandom_range(201, 600);
        end
      end
      tail_val = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(1, KEY_MAX / 2);
      step_max = (KEY_MAX - tail_val) / len;
      // Tight steps pack the list with duplicates.
      if ($urandom_range(0, 3) == 0) step_max = $urandom_range(0, 3);

      grow_list(len, 1'b1, ordered);
      search_some($urandom_range(2, 10));
      // Extend the same list without a restart now and then.
      if ($urandom_range(0, 3) == 0) begin
        grow_list($urandom_range(1, 15), 1'b0, ordered);
        search_some($urandom_range(1, 6));
      end
      if ($urandom_range(0, 4) == 0) drain_results();
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Ran %0d appends (%0d dropped on a full store) and %0d searches.",
             sb.appends, sb.dropped, sb.searches);
    $display("%0d searches hit; %0d reported an overflowed list.",
             sb.hits, sb.ovf_results);
    if (sb.mismatches == 0) begin
      $display("indexed_sequential_search test passed");
    end else begin
      $display("indexed_sequential_search test failed");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/isrch_pkg.sv
rtl/core/isrch_if.sv
rtl/core/isrch_store.sv
rtl/core/indexed_sequential_search.sv
rtl/core/isrch_chk.sv
tb/tb_indexed_sequential_search.sv
